@@ hw/rtl/pli_pkg.sv @@
// Package for the piecewise linear interpolation table.
// Widths, register indexes, opcodes, reset values and the structs shared by
// the table memory, the serial divider and the query engine. No dependencies.
package pli_pkg;

  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 6;

  localparam int MIN_POINTS = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TOL     = 4'd1;

  localparam logic [CNT_W-1:0] RST_POINT_COUNT = 9'd2;
  localparam logic [TOL_W-1:0] RST_END_TOL     = 16'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] grid;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] rem_init;
    logic [DATA_W-1:0] dividend_lo;
    logic [DATA_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

endpackage

@@ hw/rtl/pli_if.sv @@
// Channel interfaces of the interpolation table: request, result and
// register write channels, each with valid/ready. Depends on pli_pkg.
interface pli_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [pli_pkg::IDX_W-1:0]        point_index;
  logic signed [pli_pkg::DATA_W-1:0] grid_position;
  logic signed [pli_pkg::DATA_W-1:0] node_value;
  logic signed [pli_pkg::DATA_W-1:0] query_position;

  modport source (output valid, opcode, point_index, grid_position, node_value,
                  query_position, input ready);
  modport sink (input valid, opcode, point_index, grid_position, node_value,
                query_position, output ready);
endinterface

interface pli_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pli_pkg::DATA_W-1:0] interpolated_value;

  modport source (output valid, interpolated_value, input ready);
  modport sink (input valid, interpolated_value, output ready);
endinterface

interface pli_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pli_pkg::CFG_IDX_W-1:0]    index;
  logic [pli_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/pli_table.sv @@
// Grid/value table memory: one write port, one read port, registered read.
// Depends on pli_pkg for the entry type.
module pli_table #(
  parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(MAX_POINTS)-1:0]     waddr,
  input  pli_pkg::entry_t                   wdata,
  input  logic [$clog2(MAX_POINTS)-1:0]     raddr,
  output pli_pkg::entry_t                   rdata
);

  pli_pkg::entry_t mem [MAX_POINTS];
  pli_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/pli_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the interval
// fraction and the end ramp. Depends on pli_pkg for the request structs.
module pli_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pli_pkg::div_req_t req,
  output pli_pkg::div_rsp_t rsp
);

  logic [pli_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [pli_pkg::DATA_W-1:0] lo_r, lo_nxt;
  logic [pli_pkg::DATA_W-1:0] quot_r, quot_nxt;
  logic [pli_pkg::DATA_W-1:0] dsr_r;
  logic [pli_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [pli_pkg::DATA_W:0]   trial;
  logic                       fits;

  // remainder stays below the divisor, so one extra bit holds the trial
  assign trial = {rem_r, lo_r[pli_pkg::DATA_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem_init;
      lo_nxt   = req.dividend_lo;
      quot_nxt = '0;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? pli_pkg::DATA_W'(trial - {1'b0, dsr_r})
                      : pli_pkg::DATA_W'(trial);
      lo_nxt   = {lo_r[pli_pkg::DATA_W-2:0], 1'b0};
      quot_nxt = {quot_r[pli_pkg::DATA_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == pli_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    quot_r <= quot_nxt;
    if (req.start) begin
      dsr_r <= req.divisor;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.quot   = quot_r;
  assign rsp.rem_nz = |rem_r;

endmodule

@@ hw/rtl/pli_core.sv @@
// Query engine: load writes, binary search over the table memory, end and
// interval evaluation, multiply and result register. Depends on pli_pkg,
// pli_if, and drives pli_table and pli_div through its ports.
module pli_core #(
  parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = pli_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pli_in_if.sink                              in_chan,
  pli_out_if.source                           out_chan,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     n_pts,
  input  logic [pli_pkg::TOL_W-1:0]           tol,
  output logic                                tbl_we,
  output logic [$clog2(MAX_POINTS)-1:0]       tbl_waddr,
  output pli_pkg::entry_t                     tbl_wdata,
  output logic [$clog2(MAX_POINTS)-1:0]       tbl_raddr,
  input  pli_pkg::entry_t                     tbl_rdata,
  output pli_pkg::div_req_t                   div_req,
  input  pli_pkg::div_rsp_t                   div_rsp
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS+1);
  localparam int DW    = pli_pkg::DATA_W;
  localparam int ACC_W = DW + FRAC_BITS + 3;
  localparam int NUM_W = DW + pli_pkg::TOL_W + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_CAPB = 4'd5;
  localparam logic [3:0] S_EVAL = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_TNUM = 4'd8;
  localparam logic [3:0] S_TDIV = 4'd9;
  localparam logic [3:0] S_IDIV = 4'd10;
  localparam logic [3:0] S_IACC = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]              state_r, state_nxt;
  logic signed [DW-1:0]    pos_r;
  logic [CW-1:0]           lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]           mid_r;
  logic signed [DW-1:0]    xa_r, qa_r, xb_r, qb_r;
  logic                    tail_r, tail_nxt;
  logic                    neg_r;
  logic signed [DW:0]      mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic signed [2*DW+1:0]  prod_r;
  logic signed [DW-1:0]    res_r, res_nxt;
  logic                    out_valid_r;
  logic signed [DW-1:0]    out_data_r;
  pli_pkg::div_req_t       div_req_r, div_req_nxt;

  logic                    accept;
  logic [CW:0]             sum_lh;
  logic [AW-1:0]           mid, idx_a, idx_b;
  logic signed [DW:0]      d_a, h_ab, tol_s;
  logic [DW:0]             abs_d;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        abs_num;
  logic signed [ACC_W-1:0] acc, acc_sh;
  logic [ACC_W-DW:0]       acc_top;
  logic                    out_free;

  assign accept       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  assign tbl_we    = accept && (in_chan.opcode == pli_pkg::OP_LOAD) &&
                     (32'(in_chan.point_index) < 32'(MAX_POINTS));
  assign tbl_waddr = AW'(in_chan.point_index);
  assign tbl_wdata = '{grid: in_chan.grid_position, value: in_chan.node_value};

  assign sum_lh = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid    = AW'(sum_lh >> 1);
  assign idx_a  = (lo_r == '0) ? '0 : AW'(lo_r - 1'b1);
  assign idx_b  = (lo_r == n_pts) ? AW'(lo_r - 1'b1) : AW'(lo_r);

  always_comb begin
    case (state_r)
      S_SRCH:  tbl_raddr = mid;
      S_RDA:   tbl_raddr = idx_a;
      S_RDB:   tbl_raddr = idx_b;
      default: tbl_raddr = idx_a;
    endcase
  end

  // distances against the left node of the interval
  assign d_a   = (DW+1)'(pos_r) - (DW+1)'(xa_r);
  assign h_ab  = (DW+1)'(xb_r) - (DW+1)'(xa_r);
  assign tol_s = (DW+1)'({1'b0, tol});
  assign abs_d = d_a[DW] ? (DW+1)'(-d_a) : (DW+1)'(d_a);

  // end ramp numerator 2*q*(tol-d) + tol
  assign num     = {prod_r[NUM_W-2:0], 1'b0} + NUM_W'(tol);
  assign abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // interval blend q_s*2^F + dq*frac + half, then floor shift
  assign acc     = (ACC_W'(qa_r) <<< FRAC_BITS) + ACC_W'(prod_r)
                   + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign acc_sh  = acc >>> FRAC_BITS;
  assign acc_top = acc_sh[ACC_W-1:DW-1];

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt   = state_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    tail_nxt    = tail_r;
    mul_a_nxt   = mul_a_r;
    mul_b_nxt   = mul_b_r;
    res_nxt     = res_r;
    div_req_nxt = div_req_r;
    div_req_nxt.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_chan.opcode == pli_pkg::OP_QUERY)) begin
          lo_nxt    = '0;
          hi_nxt    = n_pts;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        state_nxt = (lo_r < hi_r) ? S_SCMP : S_RDA;
      end
      S_SCMP: begin
        if (tbl_rdata.grid < pos_r) begin
          lo_nxt = CW'(mid_r) + 1'b1;
        end else begin
          hi_nxt = CW'(mid_r);
        end
        state_nxt = S_SRCH;
      end
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_CAPB;
      S_CAPB: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_DONE;
        if (lo_r == '0) begin
          res_nxt = (abs_d < (DW+1)'({1'b0, tol})) ? qa_r : '0;
        end else if (lo_r == n_pts) begin
          if (d_a <= 0) begin
            res_nxt = qa_r;
          end else if (d_a >= tol_s) begin
            res_nxt = '0;
          end else begin
            mul_a_nxt = (DW+1)'(qa_r);
            mul_b_nxt = tol_s - d_a;
            tail_nxt  = 1'b1;
            state_nxt = S_MUL;
          end
        end else begin
          if (h_ab <= 0) begin
            res_nxt = qb_r;
          end else if (d_a <= 0) begin
            res_nxt = qa_r;
          end else if (d_a >= h_ab) begin
            res_nxt = qb_r;
          end else begin
            div_req_nxt.start       = 1'b1;
            div_req_nxt.rem_init    = DW'(d_a);
            div_req_nxt.dividend_lo = '0;
            div_req_nxt.divisor     = DW'(h_ab);
            div_req_nxt.steps       = pli_pkg::STEP_W'(FRAC_BITS);
            tail_nxt                = 1'b0;
            state_nxt               = S_IDIV;
          end
        end
      end
      S_IDIV: begin
        if (div_rsp.done) begin
          mul_a_nxt = (DW+1)'(qb_r) - (DW+1)'(qa_r);
          mul_b_nxt = {1'b0, div_rsp.quot};
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = tail_r ? S_TNUM : S_IACC;
      end
      S_TNUM: begin
        div_req_nxt.start       = 1'b1;
        div_req_nxt.rem_init    = DW'(abs_num[NUM_W-1:DW]);
        div_req_nxt.dividend_lo = abs_num[DW-1:0];
        div_req_nxt.divisor     = DW'({tol, 1'b0});
        div_req_nxt.steps       = pli_pkg::STEP_W'(DW);
        state_nxt               = S_TDIV;
      end
      S_TDIV: begin
        if (div_rsp.done) begin
          // floor of a negative quotient: negate and step down on a remainder
          res_nxt = neg_r ? DW'(-div_rsp.quot - DW'(div_rsp.rem_nz))
                          : div_rsp.quot;
          state_nxt = S_DONE;
        end
      end
      S_IACC: begin
        if ((acc_top == '0) || (acc_top == '1)) begin
          res_nxt = acc_sh[DW-1:0];
        end else begin
          res_nxt = acc_sh[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        state_nxt = S_IACC;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      div_req_r.start <= div_req_nxt.start;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    tail_r  <= tail_nxt;
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    res_r   <= res_nxt;
    div_req_r.rem_init    <= div_req_nxt.rem_init;
    div_req_r.dividend_lo <= div_req_nxt.dividend_lo;
    div_req_r.divisor     <= div_req_nxt.divisor;
    div_req_r.steps       <= div_req_nxt.steps;
    if (state_r == S_IDLE) begin
      pos_r <= in_chan.query_position;
    end
    if (state_r == S_SRCH) begin
      mid_r <= mid;
    end
    if (state_r == S_RDB) begin
      xa_r <= tbl_rdata.grid;
      qa_r <= tbl_rdata.value;
    end
    if (state_r == S_CAPB) begin
      xb_r <= tbl_rdata.grid;
      qb_r <= tbl_rdata.value;
    end
    if (state_r == S_MUL) begin
      prod_r <= mul_a_r * mul_b_r;
    end
    if (state_r == S_TNUM) begin
      neg_r <= num[NUM_W-1];
    end
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign div_req                     = div_req_r;
  assign out_chan.valid              = out_valid_r;
  assign out_chan.interpolated_value = out_data_r;

endmodule

@@ hw/rtl/piecewise_linear_interpolator_top.sv @@
// Top level of the piecewise linear interpolation table: register port,
// point count clamp, and the table memory, divider and query engine.
// Depends on pli_pkg, pli_if, pli_table, pli_div and pli_core.
//
//   channel   role    handshake       payload
//   in_chan   sink    valid/ready     opcode, point_index, grid_position,
//                                     node_value, query_position
//   out_chan  source  valid/ready     interpolated_value
//   cfg_chan  sink    valid/ready     index, data (always ready)
//
// A load gives no result. A query does a binary search, one memory read then a
// compare per probe (ceil(log2(n+1)) probes), reads of both nodes and the
// evaluation, and where it is needed the serial divider: FRAC_BITS steps for
// an interval, 32 steps on the ramp above the last node. One request is in
// flight at a time; a pending result in the output register stalls only the
// next result.
// Reset is synchronous; the table memory is not cleared.
module piecewise_linear_interpolator_top #(
  parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = pli_pkg::DEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  pli_in_if.sink     in_chan,
  pli_out_if.source  out_chan,
  pli_cfg_if.sink    cfg_chan
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS+1);

  logic [pli_pkg::CNT_W-1:0] point_count_r;
  logic [pli_pkg::TOL_W-1:0] end_tol_r;
  logic [CW-1:0]             n_pts;

  logic                      tbl_we;
  logic [AW-1:0]             tbl_waddr, tbl_raddr;
  pli_pkg::entry_t           tbl_wdata, tbl_rdata;
  pli_pkg::div_req_t         div_req;
  pli_pkg::div_rsp_t         div_rsp;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= pli_pkg::RST_POINT_COUNT;
      end_tol_r     <= pli_pkg::RST_END_TOL;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        pli_pkg::REG_POINT_COUNT: point_count_r <= pli_pkg::CNT_W'(cfg_chan.data);
        pli_pkg::REG_END_TOL:     end_tol_r     <= pli_pkg::TOL_W'(cfg_chan.data);
        default: ;
      endcase
    end
  end

  // clamp the point count into two up to the table depth
  always_comb begin
    if (32'(point_count_r) < 32'(pli_pkg::MIN_POINTS)) begin
      n_pts = CW'(pli_pkg::MIN_POINTS);
    end else if (32'(point_count_r) > 32'(MAX_POINTS)) begin
      n_pts = CW'(MAX_POINTS);
    end else begin
      n_pts = CW'(point_count_r);
    end
  end

  pli_table #(
    .MAX_POINTS(MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  pli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pli_core #(
    .MAX_POINTS(MAX_POINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .n_pts     (n_pts),
    .tol       (end_tol_r),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

endmodule
